// File: src/ssg_pkg.sv
// Shared constants, types and helpers for the sinusoid similarity grouping block.
package ssg_pkg;

  localparam int PARAM_WIDTH = 24;
  localparam int PHASE_BITS = 16;
  localparam int LABEL_W = 31;
  localparam int DIFF_W = 32;
  localparam int LIMIT_W = 16;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_USE_GOOD_MASK = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MEAN_DIFF_LIMIT = 1'd1;

  localparam logic [LIMIT_W-1:0] MEAN_DIFF_LIMIT_RESET = 16'd1792;

  localparam int ANGLE_W = 32;
  localparam int ANG_SHIFT = 33 - PHASE_BITS;
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 32'h4000_0000;

  localparam int CORDIC_STEPS = 24;
  localparam int XY_W = 34;
  localparam int Z_W = 34;
  localparam int SINE_W = 19;
  localparam int ROUND_SHIFT = 14;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN_INV = 34'sd652032874;
  localparam logic signed [XY_W-1:0] ROUND_BIAS = 34'sd8192;

  localparam logic [ANGLE_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Fold register, one register per rotation step, rounding register.
  localparam int SINE_LAT = CORDIC_STEPS + 2;
  // Products, differences, magnitudes, maxima, output.
  localparam int NSTAGE = SINE_LAT + 5;

  localparam int Q_SHIFT = 16;
  localparam int OFF_W = PARAM_WIDTH + 1;
  localparam int PROD_W = PARAM_WIDTH + SINE_W;
  localparam int P_W = PROD_W + 1;
  localparam int D_W = OFF_W + Q_SHIFT;
  localparam int AB_W = (P_W > D_W) ? P_W : D_W;
  localparam int SUM_W = AB_W + 3;

  typedef struct packed {
    logic unassigned;
    logic good;
    logic [LABEL_W-1:0] label;
  } flags_t;

  typedef struct packed {
    logic signed [PARAM_WIDTH-1:0] amp_ref;
    logic signed [PARAM_WIDTH-1:0] amp_nb;
    logic signed [OFF_W-1:0] off_diff;
    flags_t flags;
  } side_t;

  function automatic logic [AB_W-1:0] magnitude(input logic signed [AB_W-1:0] v);
    return v[AB_W-1] ? AB_W'(-v) : AB_W'(v);
  endfunction

endpackage

// File: src/ssg_sine.sv
// Pipelined CORDIC sine of a turn angle, one rotation step per register stage.
module ssg_sine (
  input  logic clk,
  input  logic advance,
  input  logic [ssg_pkg::ANGLE_W-1:0] angle,
  output logic signed [ssg_pkg::SINE_W-1:0] sine
);
  import ssg_pkg::*;

  logic signed [XY_W-1:0] x [0:CORDIC_STEPS];
  logic signed [XY_W-1:0] y [0:CORDIC_STEPS];
  logic signed [Z_W-1:0] z [0:CORDIC_STEPS];
  logic neg [0:CORDIC_STEPS];
  logic fold;
  logic signed [XY_W-1:0] rounded;

  // Second and third quadrants are turned by half a turn and negated at the end.
  assign fold = angle[ANGLE_W-1] ^ angle[ANGLE_W-2];

  always_ff @(posedge clk) begin
    if (advance) begin
      x[0] <= CORDIC_GAIN_INV;
      y[0] <= '0;
      z[0] <= Z_W'($signed({angle[ANGLE_W-1] ^ fold, angle[ANGLE_W-2:0]}));
      neg[0] <= fold;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (advance) begin
        if (!z[i][Z_W-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - $signed(Z_W'(ATAN_TURNS[i]));
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + $signed(Z_W'(ATAN_TURNS[i]));
        end
        neg[i+1] <= neg[i];
      end
    end
  end

  assign rounded = (y[CORDIC_STEPS] + ROUND_BIAS) >>> ROUND_SHIFT;

  always_ff @(posedge clk) begin
    if (advance) begin
      sine <= neg[CORDIC_STEPS] ? SINE_W'(-rounded) : SINE_W'(rounded);
    end
  end

endmodule

// File: src/sinusoid_similarity_grouping.sv
// Top level of the sinusoid similarity grouping pipeline.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------------
//  item     | item_valid, item_stall  | ref/nb amplitude, offset, phase, flags, label
//  result   | result_valid, result_stall | joins, write_label, diff_sum
//  config   | cfg_write               | cfg_index, cfg_data
//
// One item enters per cycle unless a result is stalled; each result passes the
// 24 rotation stages of the sine units plus fold, rounding and five arithmetic stages.
// Reset clears the valid bits and loads the register defaults.
// A stalled result holds the whole pipeline, and item_stall follows it in the same cycle.
module sinusoid_similarity_grouping (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_stall,
  input  logic signed [ssg_pkg::PARAM_WIDTH-1:0] ref_amplitude,
  input  logic signed [ssg_pkg::PARAM_WIDTH-1:0] ref_offset,
  input  logic [ssg_pkg::PHASE_BITS-1:0] ref_phase,
  input  logic signed [ssg_pkg::PARAM_WIDTH-1:0] nb_amplitude,
  input  logic signed [ssg_pkg::PARAM_WIDTH-1:0] nb_offset,
  input  logic [ssg_pkg::PHASE_BITS-1:0] nb_phase,
  input  logic nb_unassigned,
  input  logic nb_good,
  input  logic [ssg_pkg::LABEL_W-1:0] label,
  output logic result_valid,
  input  logic result_stall,
  output logic joins,
  output logic [ssg_pkg::LABEL_W-1:0] write_label,
  output logic [ssg_pkg::DIFF_W-1:0] diff_sum,
  input  logic cfg_write,
  input  logic [ssg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ssg_pkg::LIMIT_W-1:0] cfg_data
);
  import ssg_pkg::*;

  logic advance;
  logic [NSTAGE-1:0] vld;
  logic use_good_mask;
  logic [LIMIT_W-1:0] mean_diff_limit;

  logic [ANGLE_W-1:0] ref_angle0, ref_angle1, nb_angle0, nb_angle1;
  logic signed [SINE_W-1:0] ref_sine0, ref_sine1, nb_sine0, nb_sine1;

  side_t side_in;
  side_t side [0:SINE_LAT-1];

  logic signed [PROD_W-1:0] prod_ref0, prod_ref1, prod_nb0, prod_nb1;
  logic signed [OFF_W-1:0] off26;
  flags_t fl26, fl27, fl28, fl29;

  logic signed [P_W-1:0] p0, p1;
  logic signed [D_W-1:0] dd;

  logic [AB_W-1:0] mag_p0, mag_p1, mag_d;
  logic [AB_W-1:0] m0, m1;

  logic [SUM_W-1:0] sum;
  logic saturated;
  logic join_next;

  assign advance = !(result_valid && result_stall);
  assign item_stall = !advance;
  assign result_valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[NSTAGE-2:0], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      use_good_mask <= 1'b1;
      mean_diff_limit <= MEAN_DIFF_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_USE_GOOD_MASK: use_good_mask <= cfg_data[0];
        REG_MEAN_DIFF_LIMIT: mean_diff_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Doubling the phase; the eight sample points repeat after four quarter turns.
  assign ref_angle0 = ANGLE_W'({ref_phase, {ANG_SHIFT{1'b0}}});
  assign nb_angle0 = ANGLE_W'({nb_phase, {ANG_SHIFT{1'b0}}});
  assign ref_angle1 = ref_angle0 + QUARTER_TURN;
  assign nb_angle1 = nb_angle0 + QUARTER_TURN;

  ssg_sine u_ref_sine0 (.clk, .advance, .angle(ref_angle0), .sine(ref_sine0));
  ssg_sine u_ref_sine1 (.clk, .advance, .angle(ref_angle1), .sine(ref_sine1));
  ssg_sine u_nb_sine0 (.clk, .advance, .angle(nb_angle0), .sine(nb_sine0));
  ssg_sine u_nb_sine1 (.clk, .advance, .angle(nb_angle1), .sine(nb_sine1));

  assign side_in.amp_ref = ref_amplitude;
  assign side_in.amp_nb = nb_amplitude;
  assign side_in.off_diff = OFF_W'(ref_offset) - OFF_W'(nb_offset);
  assign side_in.flags.unassigned = nb_unassigned;
  assign side_in.flags.good = nb_good;
  assign side_in.flags.label = label;

  always_ff @(posedge clk) begin
    if (advance) begin
      side[0] <= side_in;
      for (int j = 1; j < SINE_LAT; j++) begin
        side[j] <= side[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod_ref0 <= PROD_W'(side[SINE_LAT-1].amp_ref) * PROD_W'(ref_sine0);
      prod_ref1 <= PROD_W'(side[SINE_LAT-1].amp_ref) * PROD_W'(ref_sine1);
      prod_nb0 <= PROD_W'(side[SINE_LAT-1].amp_nb) * PROD_W'(nb_sine0);
      prod_nb1 <= PROD_W'(side[SINE_LAT-1].amp_nb) * PROD_W'(nb_sine1);
      off26 <= side[SINE_LAT-1].off_diff;
      fl26 <= side[SINE_LAT-1].flags;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p0 <= P_W'(prod_ref0) - P_W'(prod_nb0);
      p1 <= P_W'(prod_ref1) - P_W'(prod_nb1);
      dd <= D_W'(off26) <<< Q_SHIFT;
      fl27 <= fl26;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mag_p0 <= magnitude(AB_W'(p0));
      mag_p1 <= magnitude(AB_W'(p1));
      mag_d <= magnitude(AB_W'(dd));
      fl28 <= fl27;
    end
  end

  // A sample and its half-turn partner give |d+p| + |d-p|, which is twice max(|d|, |p|).
  always_ff @(posedge clk) begin
    if (advance) begin
      m0 <= (mag_p0 > mag_d) ? mag_p0 : mag_d;
      m1 <= (mag_p1 > mag_d) ? mag_p1 : mag_d;
      fl29 <= fl28;
    end
  end

  assign sum = (SUM_W'(m0) + SUM_W'(m1)) << 2;
  assign saturated = (sum >> (DIFF_W + Q_SHIFT)) != '0;
  assign join_next = fl29.unassigned && (!use_good_mask || fl29.good) &&
                     (sum < SUM_W'({mean_diff_limit, 19'b0}));

  always_ff @(posedge clk) begin
    if (advance) begin
      joins <= join_next;
      write_label <= join_next ? fl29.label : '0;
      diff_sum <= saturated ? '1 : DIFF_W'(sum >> Q_SHIFT);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_label_without_join: assert property (@(posedge clk) disable iff (rst)
    result_valid && !joins |-> write_label == '0)
    else $error("write_label set on an item that does not join");

  a_join_below_limit: assert property (@(posedge clk) disable iff (rst)
    result_valid && joins |-> diff_sum < DIFF_W'({mean_diff_limit, 3'b000}))
    else $error("join reported with a difference sum at or above the limit");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(vld))
    else $error("pipeline valid bits moved while stalled");

  a_assigned_never_joins: assert property (@(posedge clk) disable iff (rst)
    vld[NSTAGE-2] && advance && !fl29.unassigned |=> !joins)
    else $error("assigned neighbour joined the feature");
`endif

endmodule
